// File: rtl/core/cau_pkg.sv
// Shared types, operation codes and status codes for the complex arithmetic unit.
`timescale 1ns / 1ps

package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QDEPTH = 4;

  localparam logic [3:0] KIND_ADD  = 4'd0;
  localparam logic [3:0] KIND_SUB  = 4'd1;
  localparam logic [3:0] KIND_MUL  = 4'd2;
  localparam logic [3:0] KIND_DIV  = 4'd3;
  localparam logic [3:0] KIND_CONJ = 4'd4;
  localparam logic [3:0] KIND_NEG  = 4'd5;
  localparam logic [3:0] KIND_EQ   = 4'd6;
  localparam logic [3:0] KIND_NORM = 4'd7;
  localparam logic [3:0] KIND_MAG  = 4'd8;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               is_equal;
    logic [1:0]         status;
  } out_t;

  // decoded operation, at most one bit set; none set for unused codes
  typedef struct packed {
    logic add;
    logic sub;
    logic mul;
    logic div;
    logic conj;
    logic neg;
    logic eq;
    logic norm;
    logic mag;
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cmd_t;

endpackage

// File: rtl/core/cau_front.sv
// Front end: accepts input transactions and decodes the operation code.
`timescale 1ns / 1ps

module cau_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  cau_pkg::in_t  in_data,
  output logic          push,
  output cau_pkg::cmd_t push_cmd,
  input  logic          q_full
);

  logic          fv;
  cau_pkg::cmd_t cmd;
  cau_pkg::op_t  op_dec;

  always_comb begin
    op_dec = '0;
    unique case (in_data.kind)
      cau_pkg::KIND_ADD:  op_dec.add  = 1'b1;
      cau_pkg::KIND_SUB:  op_dec.sub  = 1'b1;
      cau_pkg::KIND_MUL:  op_dec.mul  = 1'b1;
      cau_pkg::KIND_DIV:  op_dec.div  = 1'b1;
      cau_pkg::KIND_CONJ: op_dec.conj = 1'b1;
      cau_pkg::KIND_NEG:  op_dec.neg  = 1'b1;
      cau_pkg::KIND_EQ:   op_dec.eq   = 1'b1;
      cau_pkg::KIND_NORM: op_dec.norm = 1'b1;
      cau_pkg::KIND_MAG:  op_dec.mag  = 1'b1;
      default:            op_dec = '0;
    endcase
  end

  assign in_stall = fv && q_full;
  assign push     = fv && !q_full;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (!in_stall) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd.op   <= op_dec;
      cmd.a_re <= in_data.a_re;
      cmd.a_im <= in_data.a_im;
      cmd.b_re <= in_data.b_re;
      cmd.b_im <= in_data.b_im;
    end
  end

endmodule

// File: rtl/core/cau_queue.sv
// Command queue between the front end and the execution pipeline.
`timescale 1ns / 1ps

module cau_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cau_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output cau_pkg::cmd_t q_cmd
);

  localparam int AW = $clog2(cau_pkg::QDEPTH);

  cau_pkg::cmd_t mem [cau_pkg::QDEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full    = (count == (AW+1)'(cau_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: rtl/core/cau_back.sv
// Execution pipeline: multipliers, sums, pipelined divider and square root.
`timescale 1ns / 1ps

module cau_back #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cau_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output cau_pkg::out_t out_data
);

  localparam int NW  = 64 + FRAC_BITS;  // shifted numerator width
  localparam int QW  = 34;              // quotient bits 33..0; bits 33 and 32 flag overflow
  localparam int EW  = NW + QW;         // compare width
  localparam int NST = QW;              // divider stages
  localparam int SQS = 32;              // root stages

  typedef struct packed {
    cau_pkg::op_t  op;
    logic [31:0]   fix_re;
    logic [31:0]   fix_im;
    logic          fix_eq;
    logic [1:0]    fix_st;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic [63:0]   den;
    logic [NW-1:0] rem_re;
    logic [NW-1:0] rem_im;
    logic [QW-1:0] q_re;
    logic [QW-1:0] q_im;
    logic [63:0]   sq_v;
    logic [63:0]   sq_r;
  } dstage_t;

  function automatic logic [32:0] sat66(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] div_sat(input logic neg, input logic [QW-1:0] q);
    logic ovf;
    logic [32:0] r;
    ovf = q[33] | q[32] | (neg ? (q[31] & (|q[30:0])) : q[31]);
    if (ovf) begin
      r = {1'b1, (neg ? 32'h8000_0000 : 32'h7fff_ffff)};
    end else begin
      r = {1'b0, (neg ? (32'd0 - q[31:0]) : q[31:0])};
    end
    return r;
  endfunction

  logic adv;
  assign adv   = !out_valid || !out_stall;
  assign q_pop = q_valid && adv;

  // ---------------- stage 1: products and simple operations
  logic signed [31:0] mb_re, mb_im;
  logic signed [63:0] p_rr_c, p_ii_c, p_ri_c, p_ir_c, p_br2_c, p_bi2_c;
  logic [32:0]        t_re, t_im;

  assign mb_re   = (q_cmd.op.norm || q_cmd.op.mag) ? q_cmd.a_re : q_cmd.b_re;
  assign mb_im   = (q_cmd.op.norm || q_cmd.op.mag) ? q_cmd.a_im : q_cmd.b_im;
  assign p_rr_c  = q_cmd.a_re * mb_re;
  assign p_ii_c  = q_cmd.a_im * mb_im;
  assign p_ri_c  = q_cmd.a_re * q_cmd.b_im;
  assign p_ir_c  = q_cmd.a_im * q_cmd.b_re;
  assign p_br2_c = q_cmd.b_re * q_cmd.b_re;
  assign p_bi2_c = q_cmd.b_im * q_cmd.b_im;

  always_comb begin
    t_re = '0;
    t_im = '0;
    if (q_cmd.op.add) begin
      t_re = sat66(66'(q_cmd.a_re) + 66'(q_cmd.b_re));
      t_im = sat66(66'(q_cmd.a_im) + 66'(q_cmd.b_im));
    end else if (q_cmd.op.sub) begin
      t_re = sat66(66'(q_cmd.a_re) - 66'(q_cmd.b_re));
      t_im = sat66(66'(q_cmd.a_im) - 66'(q_cmd.b_im));
    end else if (q_cmd.op.conj) begin
      t_re = {1'b0, q_cmd.a_re};
      t_im = sat66(66'sd0 - 66'(q_cmd.a_im));
    end else if (q_cmd.op.neg) begin
      t_re = sat66(66'sd0 - 66'(q_cmd.a_re));
      t_im = sat66(66'sd0 - 66'(q_cmd.a_im));
    end
  end

  logic               s1_v;
  cau_pkg::op_t       s1_op;
  logic signed [63:0] s1_rr, s1_ii, s1_ri, s1_ir, s1_br2, s1_bi2;
  logic [31:0]        s1_re, s1_im;
  logic               s1_eq;
  logic [1:0]         s1_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op  <= q_cmd.op;
      s1_rr  <= p_rr_c;
      s1_ii  <= p_ii_c;
      s1_ri  <= p_ri_c;
      s1_ir  <= p_ir_c;
      s1_br2 <= p_br2_c;
      s1_bi2 <= p_bi2_c;
      s1_re  <= t_re[31:0];
      s1_im  <= t_im[31:0];
      s1_eq  <= q_cmd.op.eq && (q_cmd.a_re == q_cmd.b_re) && (q_cmd.a_im == q_cmd.b_im);
      s1_st  <= (t_re[32] || t_im[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
  end

  // ---------------- stage 2: exact sums of products
  logic               s2_v;
  cau_pkg::op_t       s2_op;
  logic signed [64:0] s2_mul_re, s2_mul_im, s2_dn_re, s2_dn_im;
  logic [63:0]        s2_den;
  logic [31:0]        s2_re, s2_im;
  logic               s2_eq;
  logic [1:0]         s2_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op     <= s1_op;
      s2_mul_re <= 65'(s1_rr) - 65'(s1_ii);
      s2_mul_im <= 65'(s1_ri) + 65'(s1_ir);
      s2_dn_re  <= 65'(s1_rr) + 65'(s1_ii);  // also the sum of squares for norm and magnitude
      s2_dn_im  <= 65'(s1_ir) - 65'(s1_ri);
      s2_den    <= $unsigned(s1_br2) + $unsigned(s1_bi2);
      s2_re     <= s1_re;
      s2_im     <= s1_im;
      s2_eq     <= s1_eq;
      s2_st     <= s1_st;
    end
  end

  // ---------------- stage 3: scaling, saturation, divider and root setup
  logic [32:0]        m_re, m_im;
  logic [64:0]        neg_re_c, neg_im_c;
  logic [63:0]        mag_re_c, mag_im_c;
  dstage_t            d0;

  assign neg_re_c = 65'd0 - $unsigned(s2_dn_re);
  assign neg_im_c = 65'd0 - $unsigned(s2_dn_im);
  assign mag_re_c = s2_dn_re[64] ? neg_re_c[63:0] : s2_dn_re[63:0];
  assign mag_im_c = s2_dn_im[64] ? neg_im_c[63:0] : s2_dn_im[63:0];

  always_comb begin
    m_re = '0;
    m_im = '0;
    if (s2_op.mul) begin
      m_re = sat66(66'(s2_mul_re >>> FRAC_BITS));
      m_im = sat66(66'(s2_mul_im >>> FRAC_BITS));
    end else if (s2_op.norm) begin
      m_re = sat66(66'(s2_dn_re >>> FRAC_BITS));
    end
    d0        = '0;
    d0.op     = s2_op;
    d0.fix_eq = s2_eq;
    if (s2_op.mul || s2_op.norm) begin
      d0.fix_re = m_re[31:0];
      d0.fix_im = m_im[31:0];
      d0.fix_st = (m_re[32] || m_im[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end else begin
      d0.fix_re = s2_re;
      d0.fix_im = s2_im;
      d0.fix_st = s2_st;
    end
    d0.dz     = (s2_den == 64'd0);
    d0.neg_re = s2_dn_re[64];
    d0.neg_im = s2_dn_im[64];
    d0.den    = s2_den;
    d0.rem_re = NW'(mag_re_c) << FRAC_BITS;
    d0.rem_im = NW'(mag_im_c) << FRAC_BITS;
    d0.sq_v   = s2_dn_re[63:0];
  end

  dstage_t dp [0:NST];
  logic    dv [0:NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dp[0] <= d0;
    end
  end

  // ---------------- divider (one quotient bit per stage) with root alongside
  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam int          SH    = QW - 1 - k;
    localparam bit          DO_SQ = (k < SQS);
    localparam int          SQSH  = DO_SQ ? (62 - 2 * k) : 0;
    localparam logic [63:0] SQB   = 64'd1 << SQSH;

    logic [EW-1:0] dsh;
    logic [63:0]   sq_t;
    dstage_t       nxt;

    always_comb begin
      nxt  = dp[k];
      dsh  = EW'(dp[k].den) << SH;
      sq_t = dp[k].sq_r + SQB;
      if (EW'(dp[k].rem_re) >= dsh) begin
        nxt.rem_re   = NW'(EW'(dp[k].rem_re) - dsh);
        nxt.q_re[SH] = 1'b1;
      end
      if (EW'(dp[k].rem_im) >= dsh) begin
        nxt.rem_im   = NW'(EW'(dp[k].rem_im) - dsh);
        nxt.q_im[SH] = 1'b1;
      end
      if (DO_SQ) begin
        if (dp[k].sq_v >= sq_t) begin
          nxt.sq_v = dp[k].sq_v - sq_t;
          nxt.sq_r = (dp[k].sq_r >> 1) + SQB;
        end else begin
          nxt.sq_r = dp[k].sq_r >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dp[k+1] <= nxt;
      end
    end
  end

  // ---------------- final selection into the output register
  cau_pkg::out_t res_c;
  logic [32:0]   dq_re, dq_im;

  assign dq_re = div_sat(dp[NST].neg_re, dp[NST].q_re);
  assign dq_im = div_sat(dp[NST].neg_im, dp[NST].q_im);

  always_comb begin
    res_c.res_re   = dp[NST].fix_re;
    res_c.res_im   = dp[NST].fix_im;
    res_c.is_equal = dp[NST].fix_eq;
    res_c.status   = dp[NST].fix_st;
    if (dp[NST].op.div) begin
      if (dp[NST].dz) begin
        res_c.res_re = '0;
        res_c.res_im = '0;
        res_c.status = cau_pkg::ST_DZ;
      end else begin
        res_c.res_re = dq_re[31:0];
        res_c.res_im = dq_im[31:0];
        res_c.status = (dq_re[32] || dq_im[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
    end else if (dp[NST].op.mag) begin
      res_c.res_re = dp[NST].sq_r[31] ? 32'h7fff_ffff : dp[NST].sq_r[31:0];
      res_c.res_im = '0;
      res_c.status = dp[NST].sq_r[31] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res_c;
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == cau_pkg::ST_DZ |-> out_data.res_re == '0 &&
      out_data.res_im == '0)
    else $error("divide-by-zero result not zero");

  a_eq_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_equal |-> out_data.status == cau_pkg::ST_OK &&
      out_data.res_re == '0 && out_data.res_im == '0)
    else $error("equal result carries data or status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status == cau_pkg::ST_OK || out_data.status == cau_pkg::ST_SAT ||
      out_data.status == cau_pkg::ST_DZ)
    else $error("undefined status code");

  a_pop_adv: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> s1_v)
    else $error("popped transaction lost at stage 1");

endmodule

// File: rtl/core/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front end, command queue, execution pipeline.
`timescale 1ns / 1ps

// Signed fixed-point complex ALU (add, sub, mul, div, conjugate, negate, equal, norm,
// magnitude) on 32-bit parts with FRAC_BITS fraction bits. It takes one transaction per
// cycle while in_stall is low and returns results in order; from input acceptance a
// result passes one front register, the queue, two product/sum stages, a setup stage,
// the 34-stage restoring divider (the square root runs in its first 32 stages) and the
// output register. A 4-entry queue after the front register absorbs short output
// stalls; a held output freezes the execution pipeline.

module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  cau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cau_pkg::out_t out_data
);

  logic          push;
  cau_pkg::cmd_t push_cmd;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  cau_pkg::cmd_t q_cmd;

  cau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  cau_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  cau_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/complex_arithmetic_unit_tb.sv
// Self-checking testbench for the complex arithmetic unit: directed table, then random traffic.
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;

  localparam int FRAC = cau_pkg::FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS = 1800;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [3:0] KIND_UNUSED_LO = 4'd9;
  localparam logic [3:0] KIND_UNUSED_HI = 4'd15;
  localparam logic signed [127:0] Q_MAX = 128'sh7fffffff;
  localparam logic signed [127:0] Q_MIN = -128'sh80000000;
  localparam cau_pkg::out_t NIL = '0;

  typedef struct packed {
    cau_pkg::in_t  stim;
    logic          typed;
    cau_pkg::out_t want;
  } row_t;

  localparam int NROWS = 22;
  localparam row_t DIRECTED [NROWS] = '{
    {cau_pkg::KIND_ADD, 32'h7fffffff, 32'h00000000, 32'h00000001, 32'h00000000,
     1'b1, 32'h7fffffff, 32'h00000000, 1'b0, cau_pkg::ST_SAT},
    {cau_pkg::KIND_ADD, 32'h80000000, 32'h80000000, 32'hffffffff, 32'h00000000,
     1'b1, 32'h80000000, 32'h80000000, 1'b0, cau_pkg::ST_SAT},
    {cau_pkg::KIND_SUB, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff,
     1'b1, 32'h80000000, 32'h7fffffff, 1'b0, cau_pkg::ST_SAT},
    {cau_pkg::KIND_SUB, 32'h00030000, 32'h00010000, 32'h00010000, 32'h00020000,
     1'b0, NIL},
    {cau_pkg::KIND_MUL, 32'h00020000, 32'h00030000, 32'h00040000, 32'hfffb0000,
     1'b0, NIL},
    {cau_pkg::KIND_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
     1'b0, NIL},
    {cau_pkg::KIND_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
     1'b0, NIL},
    {cau_pkg::KIND_MUL, 32'hffffffff, 32'h00000000, 32'h00000001, 32'h00000000,
     1'b0, NIL},
    {cau_pkg::KIND_DIV, 32'h12345678, 32'h9abcdef0, 32'h00000000, 32'h00000000,
     1'b1, 32'h00000000, 32'h00000000, 1'b0, cau_pkg::ST_DZ},
    {cau_pkg::KIND_DIV, 32'h00050000, 32'hfffd0000, 32'h00010000, 32'h00020000,
     1'b0, NIL},
    {cau_pkg::KIND_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h00000000,
     1'b0, NIL},
    {cau_pkg::KIND_DIV, 32'hffffffff, 32'h00000001, 32'h80000000, 32'h7fffffff,
     1'b0, NIL},
    {cau_pkg::KIND_CONJ, 32'h00000005, 32'h80000000, 32'h11111111, 32'h22222222,
     1'b1, 32'h00000005, 32'h7fffffff, 1'b0, cau_pkg::ST_SAT},
    {cau_pkg::KIND_NEG, 32'h80000000, 32'h00000000, 32'h00000000, 32'h00000000,
     1'b1, 32'h7fffffff, 32'h00000000, 1'b0, cau_pkg::ST_SAT},
    {cau_pkg::KIND_NEG, 32'h7fffffff, 32'hffffffff, 32'h00000000, 32'h00000000,
     1'b1, 32'h80000001, 32'h00000001, 1'b0, cau_pkg::ST_OK},
    {cau_pkg::KIND_EQ, 32'hdeadbeef, 32'h0badf00d, 32'hdeadbeef, 32'h0badf00d,
     1'b1, 32'h00000000, 32'h00000000, 1'b1, cau_pkg::ST_OK},
    {cau_pkg::KIND_EQ, 32'hdeadbeef, 32'h0badf00d, 32'hdeadbeef, 32'h0badf00c,
     1'b1, 32'h00000000, 32'h00000000, 1'b0, cau_pkg::ST_OK},
    {cau_pkg::KIND_NORM, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
     1'b1, 32'h00000000, 32'h00000000, 1'b0, cau_pkg::ST_OK},
    {cau_pkg::KIND_NORM, 32'h00030000, 32'hfffc0000, 32'h00000000, 32'h00000000,
     1'b0, NIL},
    {cau_pkg::KIND_MAG, 32'h80000000, 32'h80000000, 32'h00000000, 32'h00000000,
     1'b1, 32'h7fffffff, 32'h00000000, 1'b0, cau_pkg::ST_SAT},
    {cau_pkg::KIND_MAG, 32'h00030000, 32'h00040000, 32'h00000000, 32'h00000000,
     1'b0, NIL},
    {KIND_UNUSED_HI, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
     1'b1, 32'h00000000, 32'h00000000, 1'b0, cau_pkg::ST_OK}
  };

  logic          clk = 1'b0;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  cau_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  cau_pkg::out_t out_data;

  cau_pkg::out_t pending_q[$];
  int   errors = 0;
  int   sent = 0;
  int   checked = 0;
  int   kind_hits[16];
  bit   hold_done = 1'b0;
  int   idle_cycles = 0;

  complex_arithmetic_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] clamp_q(input logic signed [127:0] v, inout bit ovf);
    if (v > Q_MAX) begin
      ovf = 1'b1;
      return 32'h7fffffff;
    end
    if (v < Q_MIN) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [31:0]  r;
    logic [31:0]  t;
    logic [127:0] sq;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (32'd1 << i);
      sq = 128'(t) * 128'(t);
      if (sq <= 128'(v)) r = t;
    end
    return r;
  endfunction

  function automatic cau_pkg::out_t complex_result(input cau_pkg::in_t x);
    logic signed [127:0] ar, ai, br, bi, den, tr, ti;
    bit   ovf;
    cau_pkg::out_t r;
    ar = $signed(x.a_re);
    ai = $signed(x.a_im);
    br = $signed(x.b_re);
    bi = $signed(x.b_im);
    ovf = 1'b0;
    r = '0;
    case (x.kind)
      cau_pkg::KIND_ADD: begin
        r.res_re = clamp_q(ar + br, ovf);
        r.res_im = clamp_q(ai + bi, ovf);
      end
      cau_pkg::KIND_SUB: begin
        r.res_re = clamp_q(ar - br, ovf);
        r.res_im = clamp_q(ai - bi, ovf);
      end
      cau_pkg::KIND_MUL: begin
        tr = (ar * br - ai * bi) >>> FRAC;
        ti = (ar * bi + ai * br) >>> FRAC;
        r.res_re = clamp_q(tr, ovf);
        r.res_im = clamp_q(ti, ovf);
      end
      cau_pkg::KIND_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = cau_pkg::ST_DZ;
        end else begin
          // signed divide truncates toward zero
          tr = ((ar * br + ai * bi) <<< FRAC) / den;
          ti = ((ai * br - ar * bi) <<< FRAC) / den;
          r.res_re = clamp_q(tr, ovf);
          r.res_im = clamp_q(ti, ovf);
        end
      end
      cau_pkg::KIND_CONJ: begin
        r.res_re = clamp_q(ar, ovf);
        r.res_im = clamp_q(-ai, ovf);
      end
      cau_pkg::KIND_NEG: begin
        r.res_re = clamp_q(-ar, ovf);
        r.res_im = clamp_q(-ai, ovf);
      end
      cau_pkg::KIND_EQ: r.is_equal = (x.a_re == x.b_re) && (x.a_im == x.b_im);
      cau_pkg::KIND_NORM: r.res_re = clamp_q((ar * ar + ai * ai) >>> FRAC, ovf);
      cau_pkg::KIND_MAG: begin
        tr = ar * ar + ai * ai;
        r.res_re = clamp_q($signed({96'd0, floor_sqrt(tr[63:0])}), ovf);
      end
      default: ;
    endcase
    if (ovf && r.status == cau_pkg::ST_OK) r.status = cau_pkg::ST_SAT;
    return r;
  endfunction

  function automatic logic [31:0] random_part();
    logic [31:0] extremes [6];
    int k;
    extremes = '{32'h80000000, 32'h7fffffff, 32'h00000000, 32'h00000001,
                 32'hffffffff, 32'h00010000};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return 32'($urandom_range(0, 32'hfffff)) - 32'h80000;
      7:          return extremes[$urandom_range(0, 5)];
      8: begin
        k = $urandom_range(0, 600);
        return 32'(k - 300) << FRAC;
      end
      default:    return 32'd0;
    endcase
  endfunction

  function automatic cau_pkg::in_t random_item();
    cau_pkg::in_t x;
    x.kind = ($urandom_range(0, 19) < 18) ? 4'($urandom_range(0, 8))
                                          : 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    x.a_re = random_part();
    x.a_im = random_part();
    x.b_re = random_part();
    x.b_im = random_part();
    if (x.kind == cau_pkg::KIND_EQ && $urandom_range(0, 1) == 0) begin
      x.b_re = x.a_re;
      x.b_im = x.a_im;
      if ($urandom_range(0, 3) == 0) x.b_im[$urandom_range(0, 31)] ^= 1'b1;
    end
    if (x.kind == cau_pkg::KIND_DIV && $urandom_range(0, 9) == 0) begin
      x.b_re = '0;
      x.b_im = '0;
    end
    return x;
  endfunction

  function automatic int gap_length(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("[%0t] result %0d: %s got %h, expected %h", $realtime, checked, field, got, want);
  endtask

  // offer one transaction and hold it until accepted
  task automatic offer(input cau_pkg::in_t x, input cau_pkg::out_t want);
    int g;
    in_data  = x;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_q.push_back(want);
    kind_hits[x.kind]++;
    sent++;
    @(negedge clk);
    g = gap_length((sent / 200) % 4 == 1);
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    cau_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected res_re", out_data.res_re, 32'd0);
      end else begin
        want = pending_q.pop_front();
        if (out_data.res_re !== want.res_re)
          report_mismatch("res_re", out_data.res_re, want.res_re);
        if (out_data.res_im !== want.res_im)
          report_mismatch("res_im", out_data.res_im, want.res_im);
        if (out_data.is_equal !== want.is_equal)
          report_mismatch("is_equal", 32'(out_data.is_equal), 32'(want.is_equal));
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
      end
      checked++;
    end
  end

  // output back-pressure, with one long hold to fill the queue
  initial begin
    int g;
    int cyc;
    out_stall = 1'b0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!hold_done && checked >= 700) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        g = gap_length((cyc / 600) % 4 == 2);
        if (g > 0) begin
          out_stall = 1'b1;
          repeat (g) @(negedge clk);
          cyc += g;
        end
        out_stall = 1'b0;
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending_q.size());
        $display("complex_arithmetic_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    cau_pkg::in_t x;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    foreach (kind_hits[k]) kind_hits[k] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NROWS; i++) begin
      x = DIRECTED[i].stim;
      offer(x, DIRECTED[i].typed ? DIRECTED[i].want : complex_result(x));
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      x = random_item();
      offer(x, complex_result(x));
    end
    in_valid = 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("%0d transactions in, %0d results checked; per kind add..mag: %0d %0d %0d",
             sent, checked, kind_hits[0], kind_hits[1], kind_hits[2]);
    $display("  %0d %0d %0d %0d %0d %0d", kind_hits[3], kind_hits[4], kind_hits[5],
             kind_hits[6], kind_hits[7], kind_hits[8]);
    $display("random gaps on both sides plus a %0d-cycle output hold; %0d mismatches",
             HOLD_CYCLES, errors);
    if (errors == 0)
      $display("complex_arithmetic_unit regression: pass");
    else
      $display("complex_arithmetic_unit regression: fail");
    $finish;
  end

endmodule

// File: complex_arithmetic_unit.f
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_queue.sv
rtl/core/cau_back.sv
rtl/core/complex_arithmetic_unit.sv
tb/complex_arithmetic_unit_tb.sv
